// ===== rtl/bvm_pkg.sv =====
package bvm_pkg;

   localparam int FIFO_DEPTH_DEF  = 8;
   localparam int AVG_COUNT_DEF   = 3;
   localparam int SAMPLE_BITS_DEF = 12;

   localparam int GAIN_W    = 22;
   localparam int GAIN_FRAC = 20;
   localparam int DROP_W    = 8;
   localparam int VOLT_W    = 12;
   localparam int PCT_W     = 7;
   localparam int SLOPE_W   = 8;
   localparam int HOLD_W    = 8;
   localparam int AD_W      = 12;
   localparam int DIV_IDX_W = $clog2(PCT_W);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [VOLT_W-1:0] VOLT_MAX    = 12'hfff;
   localparam logic [HOLD_W-1:0] HOLD_INIT   = 8'hff;
   localparam logic [HOLD_W-1:0] HOLD_RELOAD = 8'd10;
   localparam logic [PCT_W-1:0]  PCT_SCALE   = 7'd100;

   localparam logic [GAIN_W-1:0]  SCALE_GAIN_RST   = 22'd647991;
   localparam logic [DROP_W-1:0]  DROP_RST         = 8'd0;
   localparam logic [VOLT_W-1:0]  CUTOFF_RST       = 12'd560;
   localparam logic [VOLT_W-1:0]  FULL_CHARGE_RST  = 12'd705;
   localparam logic [VOLT_W-1:0]  FULL_DISCH_RST   = 12'd655;
   localparam logic [SLOPE_W-1:0] SLOPE_RST        = 8'd1;
   localparam logic [PCT_W-1:0]   LOW_SET_RST      = 7'd10;
   localparam logic [PCT_W-1:0]   LOW_CLEAR_RST    = 7'd30;
   localparam logic [VOLT_W-1:0]  REF_VOLT_RST     = 12'd655;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_REF    = 2'd2
   } req_type_type;

   typedef enum logic [2:0] {
      REG_SCALE_GAIN   = 3'd0,
      REG_DROP         = 3'd1,
      REG_CUTOFF       = 3'd2,
      REG_FULL_CHARGE  = 3'd3,
      REG_FULL_DISCH   = 3'd4,
      REG_SLOPE        = 3'd5,
      REG_LOW_SET      = 3'd6,
      REG_LOW_CLEAR    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  scale_gain;
      logic [DROP_W-1:0]  drop_voltage;
      logic [VOLT_W-1:0]  cutoff_voltage;
      logic [VOLT_W-1:0]  full_charge_voltage;
      logic [VOLT_W-1:0]  full_discharge_voltage;
      logic [SLOPE_W-1:0] slope_threshold;
      logic [PCT_W-1:0]   low_set_percent;
      logic [PCT_W-1:0]   low_clear_percent;
   } cfg_type;

   typedef struct packed {
      logic                 sample_wr;
      logic                 ref_reload;
      logic                 tick_start;
      logic                 pop_rd;
      logic                 avg_load;
      logic                 mul_load;
      logic                 volt_load;
      logic                 trend_load;
      logic                 prep_load;
      logic                 div_step;
      logic [DIV_IDX_W-1:0] div_bit;
      logic                 out_load;
   } cmd_type;

   typedef struct packed {
      logic enough;
      logic full;
      logic empty;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/bvm_ctrl.sv =====
module bvm_ctrl import bvm_pkg::*; #(
   parameter int AVG_COUNT = AVG_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_type,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       req_stall
);

   localparam int CNT_W = ($clog2(AVG_COUNT) > DIV_IDX_W) ? $clog2(AVG_COUNT) : DIV_IDX_W;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_POP   = 10'b00_0000_0010,
      ST_LAST  = 10'b00_0000_0100,
      ST_AVG   = 10'b00_0000_1000,
      ST_MUL   = 10'b00_0001_0000,
      ST_VOLT  = 10'b00_0010_0000,
      ST_TREND = 10'b00_0100_0000,
      ST_PREP  = 10'b00_1000_0000,
      ST_DIV   = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_type_type'(req_type))
                  REQ_SAMPLE: cmd.sample_wr = !sts.full;
                  REQ_REF:    cmd.ref_reload = 1'b1;
                  REQ_TICK: begin
                     cmd.tick_start = 1'b1;
                     cnt_in         = '0;
                     state_in       = sts.enough ? ST_POP : ST_MUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_POP: begin
            cmd.pop_rd = 1'b1;
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(AVG_COUNT - 1)) state_in = ST_LAST;
         end
         // last read word lands in the accumulator here
         ST_LAST: state_in = ST_AVG;
         ST_AVG: begin
            cmd.avg_load = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_VOLT;
         end
         ST_VOLT: begin
            cmd.volt_load = 1'b1;
            state_in      = ST_TREND;
         end
         ST_TREND: begin
            cmd.trend_load = 1'b1;
            state_in       = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep_load = 1'b1;
            cnt_in        = CNT_W'(PCT_W - 1);
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_bit  = cnt_ff[DIV_IDX_W-1:0];
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/bvm_datapath.sv =====
module bvm_datapath import bvm_pkg::*; #(
   parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
   parameter int AVG_COUNT   = AVG_COUNT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  cfg_type                cfg,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [VOLT_W-1:0]      rsp_volt_centi,
   output logic [PCT_W-1:0]       rsp_percent,
   output logic                   rsp_charging,
   output logic                   rsp_low_flag,
   output logic                   rsp_below_cutoff,
   output logic [AD_W-1:0]        rsp_filtered_ad,
   output logic                   rsp_updated
);

   localparam int PTR_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(AVG_COUNT);
   localparam int RSHIFT  = SUM_W + 2;
   localparam int RECIP_W = RSHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RSHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
   localparam int AVGP_W  = SUM_W + RECIP_W;
   localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
   localparam int VSUM_W  = (SAMPLE_BITS + 3 > VOLT_W + 1) ? SAMPLE_BITS + 3 : VOLT_W + 1;
   localparam int NUM_W   = VOLT_W + PCT_W;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   logic [SAMPLE_BITS-1:0] fifo_mem [FIFO_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   logic [PTR_W-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   updated_ff, updated_in;
   logic [SAMPLE_BITS-1:0] filtered_ff, filtered_in;
   logic [VOLT_W-1:0]      ref_ff, ref_in;
   logic                   trend_ff, trend_in;
   logic                   low_ff, low_in;
   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [VOLT_W-1:0]      volt_ff, volt_in;
   logic [NUM_W-1:0]       rem_ff, rem_in;
   logic [VOLT_W-1:0]      den_ff, den_in;
   logic                   degen_ff, degen_in;
   logic [PCT_W-1:0]       quo_ff, quo_in;

   logic [VOLT_W-1:0]      out_volt_ff, out_volt_in;
   logic [PCT_W-1:0]       out_pct_ff, out_pct_in;
   logic                   out_chg_ff, out_chg_in;
   logic                   out_low_ff, out_low_in;
   logic                   out_below_ff, out_below_in;
   logic [AD_W-1:0]        out_ad_ff, out_ad_in;
   logic                   out_upd_ff, out_upd_in;

   logic [AVGP_W-1:0]      avg_prod;
   logic [VSUM_W-1:0]      vsum;
   logic signed [VOLT_W+1:0] diff, thr;
   logic [VOLT_W-1:0]      full_sel, vclamp;
   logic [NUM_W-1:0]       den_shift;
   logic [PCT_W-1:0]       pct;

   assign avg_prod  = AVGP_W'(sum_ff) * AVGP_W'(RECIP);
   assign vsum      = VSUM_W'(prod_ff >> GAIN_FRAC) + VSUM_W'(cfg.drop_voltage);
   assign diff      = $signed({2'b00, volt_ff}) - $signed({2'b00, ref_ff});
   assign thr       = $signed((VOLT_W + 2)'(cfg.slope_threshold));
   assign full_sel  = trend_ff ? cfg.full_charge_voltage : cfg.full_discharge_voltage;
   assign vclamp    = (volt_ff < cfg.cutoff_voltage) ? cfg.cutoff_voltage :
                      (volt_ff > full_sel) ? full_sel : volt_ff;
   assign den_shift = NUM_W'(den_ff) << cmd.div_bit;
   assign pct       = degen_ff ? '0 : quo_ff;

   assign sts.enough   = (count_ff >= CNT_W'(AVG_COUNT));
   assign sts.full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign sts.empty    = (count_ff == '0);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rd_vld_in    = cmd.pop_rd;
      updated_in   = updated_ff;
      filtered_in  = filtered_ff;
      ref_in       = ref_ff;
      trend_in     = trend_ff;
      low_in       = low_ff;
      hold_in      = hold_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      volt_in      = volt_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      degen_in     = degen_ff;
      quo_in       = quo_ff;
      out_volt_in  = out_volt_ff;
      out_pct_in   = out_pct_ff;
      out_chg_in   = out_chg_ff;
      out_low_in   = out_low_ff;
      out_below_in = out_below_ff;
      out_ad_in    = out_ad_ff;
      out_upd_in   = out_upd_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.sample_wr) begin
         tail_in  = ptr_next(tail_ff);
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pop_rd) begin
         head_in  = ptr_next(head_ff);
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.tick_start) begin
         sum_in     = '0;
         updated_in = sts.enough;
      end else if (rd_vld_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data_ff);
      end

      if (cmd.ref_reload && hold_ff != HOLD_INIT) hold_in = HOLD_RELOAD;

      if (cmd.avg_load)  filtered_in = SAMPLE_BITS'(avg_prod >> RSHIFT);
      if (cmd.mul_load)  prod_in = PROD_W'(filtered_ff) * PROD_W'(cfg.scale_gain);
      if (cmd.volt_load) volt_in = (vsum > VSUM_W'(VOLT_MAX)) ? VOLT_MAX : VOLT_W'(vsum);

      if (cmd.trend_load && updated_ff) begin
         if (hold_ff == '0 || hold_ff == HOLD_INIT) begin
            hold_in = '0;
            if (diff > thr) begin
               trend_in = 1'b1;
               ref_in   = volt_ff;
            end else if (diff < -thr) begin
               trend_in = 1'b0;
               ref_in   = volt_ff;
            end
         end else begin
            hold_in = hold_ff - HOLD_W'(1);
            ref_in  = volt_ff;
         end
      end

      if (cmd.prep_load) begin
         rem_in   = NUM_W'(vclamp - cfg.cutoff_voltage) * NUM_W'(PCT_SCALE);
         den_in   = full_sel - cfg.cutoff_voltage;
         degen_in = (full_sel <= cfg.cutoff_voltage);
         quo_in   = '0;
      end

      // one restoring quotient bit per step, most significant first
      if (cmd.div_step && rem_ff >= den_shift) begin
         rem_in              = rem_ff - den_shift;
         quo_in[cmd.div_bit] = 1'b1;
      end

      if (cmd.out_load) begin
         if (pct < cfg.low_set_percent) low_in = 1'b1;
         else if (pct >= cfg.low_clear_percent) low_in = 1'b0;
         out_volt_in  = volt_ff;
         out_pct_in   = pct;
         out_chg_in   = trend_ff;
         out_low_in   = low_in;
         out_below_in = (volt_ff < cfg.cutoff_voltage);
         out_ad_in    = AD_W'(filtered_ff);
         out_upd_in   = updated_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_wr) fifo_mem[tail_ff] <= req_sample;
      if (cmd.pop_rd) rd_data_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         updated_ff   <= 1'b0;
         filtered_ff  <= '0;
         ref_ff       <= REF_VOLT_RST;
         trend_ff     <= 1'b0;
         low_ff       <= 1'b0;
         hold_ff      <= HOLD_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         updated_ff   <= updated_in;
         filtered_ff  <= filtered_in;
         ref_ff       <= ref_in;
         trend_ff     <= trend_in;
         low_ff       <= low_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      volt_ff      <= volt_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      degen_ff     <= degen_in;
      quo_ff       <= quo_in;
      out_volt_ff  <= out_volt_in;
      out_pct_ff   <= out_pct_in;
      out_chg_ff   <= out_chg_in;
      out_low_ff   <= out_low_in;
      out_below_ff <= out_below_in;
      out_ad_ff    <= out_ad_in;
      out_upd_ff   <= out_upd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_volt_centi   = out_volt_ff;
   assign rsp_percent      = out_pct_ff;
   assign rsp_charging     = out_chg_ff;
   assign rsp_low_flag     = out_low_ff;
   assign rsp_below_cutoff = out_below_ff;
   assign rsp_filtered_ad  = out_ad_ff;
   assign rsp_updated      = out_upd_ff;

endmodule

// ===== rtl/battery_voltage_monitor_core.sv =====
// Battery voltage monitor. Sample requests push a raw AD count into a FIFO of FIFO_DEPTH
// words (dropped when full); reference requests reload the 10-tick trend hold-off once
// the trend has first updated. A tick request gives one result: when AVG_COUNT samples
// are queued it pops and averages them; it scales the latest average to centivolts,
// updates the charge trend if it averaged, and then computes percent, low flag and
// cut-off flag. Averaging runs through the one-word-per-cycle FIFO read port, and every
// tick runs the seven-step percent divider. The result sits in an output register, so
// the next request is taken while it waits. FIFO words hold no reset value and are never
// read before being written.
module battery_voltage_monitor_core import bvm_pkg::*; #(
   parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
   parameter int AVG_COUNT   = AVG_COUNT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_type,
   input  logic [SAMPLE_BITS-1:0] req_sample,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VOLT_W-1:0]      rsp_volt_centi,
   output logic [PCT_W-1:0]       rsp_percent,
   output logic                   rsp_charging,
   output logic                   rsp_low_flag,
   output logic                   rsp_below_cutoff,
   output logic [AD_W-1:0]        rsp_filtered_ad,
   output logic                   rsp_updated,

   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   cfg_type       cfg_ff, cfg_in;
   cmd_type       cmd;
   sts_type       sts;
   reg_index_type csr_idx;
   logic          csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_SCALE_GAIN:  cfg_in.scale_gain             = pwdata[GAIN_W-1:0];
            REG_DROP:        cfg_in.drop_voltage           = pwdata[DROP_W-1:0];
            REG_CUTOFF:      cfg_in.cutoff_voltage         = pwdata[VOLT_W-1:0];
            REG_FULL_CHARGE: cfg_in.full_charge_voltage    = pwdata[VOLT_W-1:0];
            REG_FULL_DISCH:  cfg_in.full_discharge_voltage = pwdata[VOLT_W-1:0];
            REG_SLOPE:       cfg_in.slope_threshold        = pwdata[SLOPE_W-1:0];
            REG_LOW_SET:     cfg_in.low_set_percent        = pwdata[PCT_W-1:0];
            REG_LOW_CLEAR:   cfg_in.low_clear_percent      = pwdata[PCT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SCALE_GAIN:  prdata = CSR_DATA_W'(cfg_ff.scale_gain);
         REG_DROP:        prdata = CSR_DATA_W'(cfg_ff.drop_voltage);
         REG_CUTOFF:      prdata = CSR_DATA_W'(cfg_ff.cutoff_voltage);
         REG_FULL_CHARGE: prdata = CSR_DATA_W'(cfg_ff.full_charge_voltage);
         REG_FULL_DISCH:  prdata = CSR_DATA_W'(cfg_ff.full_discharge_voltage);
         REG_SLOPE:       prdata = CSR_DATA_W'(cfg_ff.slope_threshold);
         REG_LOW_SET:     prdata = CSR_DATA_W'(cfg_ff.low_set_percent);
         REG_LOW_CLEAR:   prdata = CSR_DATA_W'(cfg_ff.low_clear_percent);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_gain             <= SCALE_GAIN_RST;
         cfg_ff.drop_voltage           <= DROP_RST;
         cfg_ff.cutoff_voltage         <= CUTOFF_RST;
         cfg_ff.full_charge_voltage    <= FULL_CHARGE_RST;
         cfg_ff.full_discharge_voltage <= FULL_DISCH_RST;
         cfg_ff.slope_threshold        <= SLOPE_RST;
         cfg_ff.low_set_percent        <= LOW_SET_RST;
         cfg_ff.low_clear_percent      <= LOW_CLEAR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bvm_ctrl #(
      .AVG_COUNT (AVG_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   bvm_datapath #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .AVG_COUNT   (AVG_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg_ff),
      .req_sample       (req_sample),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_volt_centi   (rsp_volt_centi),
      .rsp_percent      (rsp_percent),
      .rsp_charging     (rsp_charging),
      .rsp_low_flag     (rsp_low_flag),
      .rsp_below_cutoff (rsp_below_cutoff),
      .rsp_filtered_ad  (rsp_filtered_ad),
      .rsp_updated      (rsp_updated)
   );

   // a finished result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

   // pops only from a non-empty FIFO
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_rd |-> !sts.empty)
      else $error("FIFO popped while empty");

   // the request side reopens right after a result is loaded
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> !req_stall)
      else $error("request side not reopened after result");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   import bvm_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DIRECTED_ROWS = 24;

   typedef struct packed {
      logic [VOLT_W-1:0] volt_centi;
      logic [PCT_W-1:0]  percent;
      logic              charging;
      logic              low_flag;
      logic              below_cutoff;
      logic [AD_W-1:0]   filtered_ad;
      logic              updated;
   } reading_type;

   typedef struct packed {
      logic [1:0]                 kind;
      logic [SAMPLE_BITS_DEF-1:0] sample;
      logic                       typed;
      reading_type                want;
   } row_type;

   localparam reading_type NO_READING = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_type = REQ_SAMPLE;
   logic [SAMPLE_BITS_DEF-1:0] req_sample = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [VOLT_W-1:0] rsp_volt_centi;
   logic [PCT_W-1:0]  rsp_percent;
   logic              rsp_charging;
   logic              rsp_low_flag;
   logic              rsp_below_cutoff;
   logic [AD_W-1:0]   rsp_filtered_ad;
   logic              rsp_updated;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   battery_voltage_monitor_core i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // monitor model state
   logic [AD_W-1:0]   ad_queue [FIFO_DEPTH_DEF];
   int unsigned       ad_head;
   int unsigned       ad_count;
   logic [AD_W-1:0]   avg_ad;
   logic [VOLT_W-1:0] ref_centivolt;
   logic              trend_up;
   logic              low_latched;
   logic [HOLD_W-1:0] holdoff;
   logic [31:0]       setting [8];
   logic [31:0]       next_setting [8];

   reading_type pending_readings [$];
   row_type     directed_rows [DIRECTED_ROWS];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 1'b0;
   int ad_level = 1000;
   int requests_sent = 0;
   int readings_checked = 0;
   int mismatches = 0;

   function automatic logic [31:0] field_mask(reg_index_type idx);
      case (idx)
         REG_SCALE_GAIN: return (32'd1 << GAIN_W) - 1;
         REG_DROP: return (32'd1 << DROP_W) - 1;
         REG_CUTOFF, REG_FULL_CHARGE, REG_FULL_DISCH: return (32'd1 << VOLT_W) - 1;
         REG_SLOPE: return (32'd1 << SLOPE_W) - 1;
         default: return (32'd1 << PCT_W) - 1;
      endcase
   endfunction

   function automatic logic [VOLT_W-1:0] centivolt_of(logic [AD_W-1:0] ad);
      logic [39:0] scaled;
      scaled = (40'(ad) * 40'(setting[REG_SCALE_GAIN])) >> GAIN_FRAC;
      scaled = scaled + 40'(setting[REG_DROP]);
      return (scaled > 40'(VOLT_MAX)) ? VOLT_MAX : scaled[VOLT_W-1:0];
   endfunction

   function automatic logic [PCT_W-1:0] percent_of(logic [VOLT_W-1:0] volt);
      int full;
      int floor_v;
      int v;
      full = trend_up ? int'(setting[REG_FULL_CHARGE]) : int'(setting[REG_FULL_DISCH]);
      floor_v = int'(setting[REG_CUTOFF]);
      v = int'(volt);
      if (full <= floor_v) return '0;
      if (v < floor_v) v = floor_v;
      else if (v > full) v = full;
      return PCT_W'((v - floor_v) * int'(PCT_SCALE) / (full - floor_v));
   endfunction

   // advance the model by one accepted request; ticks queue one reading
   function automatic void absorb_request(logic [1:0] kind, logic [AD_W-1:0] sample);
      reading_type r;
      int sum;
      int diff;
      int thr;
      logic [VOLT_W-1:0] volt;
      r = '0;
      case (kind)
         REQ_SAMPLE: begin
            if (ad_count < FIFO_DEPTH_DEF) begin
               ad_queue[(ad_head + ad_count) % FIFO_DEPTH_DEF] = sample;
               ad_count++;
            end
         end
         REQ_REF: begin
            if (holdoff != HOLD_INIT) holdoff = HOLD_RELOAD;
         end
         REQ_TICK: begin
            if (ad_count >= AVG_COUNT_DEF) begin
               sum = 0;
               for (int i = 0; i < AVG_COUNT_DEF; i++) begin
                  sum += int'(ad_queue[ad_head]);
                  ad_head = (ad_head + 1) % FIFO_DEPTH_DEF;
               end
               ad_count -= AVG_COUNT_DEF;
               avg_ad = AD_W'(sum / AVG_COUNT_DEF);
               volt = centivolt_of(avg_ad);
               if (holdoff == '0 || holdoff == HOLD_INIT) begin
                  holdoff = '0;
                  diff = int'(volt) - int'(ref_centivolt);
                  thr = int'(setting[REG_SLOPE]);
                  if (diff > thr) begin
                     trend_up = 1'b1;
                     ref_centivolt = volt;
                  end else if (diff < -thr) begin
                     trend_up = 1'b0;
                     ref_centivolt = volt;
                  end
               end else begin
                  holdoff = holdoff - 1'b1;
                  ref_centivolt = volt;
               end
               r.updated = 1'b1;
            end
            volt = centivolt_of(avg_ad);
            r.percent = percent_of(volt);
            if (r.percent < setting[REG_LOW_SET]) low_latched = 1'b1;
            else if (r.percent >= setting[REG_LOW_CLEAR]) low_latched = 1'b0;
            r.volt_centi = volt;
            r.charging = trend_up;
            r.low_flag = low_latched;
            r.below_cutoff = (volt < setting[REG_CUTOFF]);
            r.filtered_ad = avg_ad;
            pending_readings.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : reading_check
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("reading arrived with none pending");
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            compare_field("volt_centi", want.volt_centi, rsp_volt_centi);
            compare_field("percent", want.percent, rsp_percent);
            compare_field("charging", want.charging, rsp_charging);
            compare_field("low_flag", want.low_flag, rsp_low_flag);
            compare_field("below_cutoff", want.below_cutoff, rsp_below_cutoff);
            compare_field("filtered_ad", want.filtered_ad, rsp_filtered_ad);
            compare_field("updated", want.updated, rsp_updated);
         end
      end
   end

   // result side: random stall, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // caller sits at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [1:0] kind, input logic [AD_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      absorb_request(kind, value);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input reg_index_type idx,
                             input logic [31:0] data, output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= CSR_ADDR_W'(int'(idx) * 4);
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      // leave the bus idle between accesses
      @(negedge clock);
   endtask

   task automatic verify_settings();
      logic [31:0] got;
      for (int i = 0; i < 8; i++) begin
         csr_access(1'b0, reg_index_type'(i), '0, got);
         if ((got & field_mask(reg_index_type'(i))) != setting[i]) begin
            $error("register %0d: expected %0d, got %0d", i, setting[i], got);
            mismatches++;
         end
      end
   endtask

   task automatic load_settings();
      logic [31:0] val;
      logic [31:0] unused;
      for (int i = 0; i < 8; i++) begin
         val = next_setting[i] & field_mask(reg_index_type'(i));
         csr_access(1'b1, reg_index_type'(i), val, unused);
         setting[i] = val;
      end
      verify_settings();
   endtask

   // drop valid, wait for every reading, then let a trailing request finish
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int clamp_ad(int v);
      if (v < 0) return 0;
      if (v > 4095) return 4095;
      return v;
   endfunction

   function automatic logic [AD_W-1:0] sample_near(int center);
      return AD_W'(clamp_ad(center + int'($urandom_range(16)) - 8));
   endfunction

   // mostly full averaging bursts around a drifting level, the rest loose requests
   task automatic random_stretch(input int items);
      int done_count;
      int roll;
      done_count = 0;
      while (done_count < items) begin
         roll = $urandom_range(99);
         if ($urandom_range(99) < 4) ad_level = $urandom_range(4095);
         else ad_level = clamp_ad(ad_level + int'($urandom_range(64)) - 32);
         if (roll < 55) begin
            repeat (AVG_COUNT_DEF) send_request(REQ_SAMPLE, sample_near(ad_level));
            send_request(REQ_TICK, AD_W'($urandom));
            done_count += AVG_COUNT_DEF + 1;
         end else if (roll < 68) begin
            if ($urandom_range(1)) send_request(REQ_SAMPLE, AD_W'($urandom));
            else send_request(REQ_SAMPLE, sample_near(ad_level));
            done_count++;
         end else if (roll < 83) begin
            send_request(REQ_TICK, AD_W'($urandom));
            done_count++;
         end else if (roll < 96) begin
            send_request(REQ_REF, AD_W'($urandom));
            done_count++;
         end else begin
            send_request(REQ_UNUSED, AD_W'($urandom));
         end
      end
   endtask

   initial begin
      setting[REG_SCALE_GAIN] = 32'(SCALE_GAIN_RST);
      setting[REG_DROP] = 32'(DROP_RST);
      setting[REG_CUTOFF] = 32'(CUTOFF_RST);
      setting[REG_FULL_CHARGE] = 32'(FULL_CHARGE_RST);
      setting[REG_FULL_DISCH] = 32'(FULL_DISCH_RST);
      setting[REG_SLOPE] = 32'(SLOPE_RST);
      setting[REG_LOW_SET] = 32'(LOW_SET_RST);
      setting[REG_LOW_CLEAR] = 32'(LOW_CLEAR_RST);
      ad_head = 0;
      ad_count = 0;
      avg_ad = '0;
      ref_centivolt = REF_VOLT_RST;
      trend_up = 1'b0;
      low_latched = 1'b0;
      holdoff = HOLD_INIT;

      directed_rows = '{
         // empty tick right after reset
         '{REQ_TICK, 12'h000, 1'b1, '{12'd0, 7'd0, 1'b0, 1'b1, 1'b1, 12'd0, 1'b0}},
         '{REQ_REF, 12'h000, 1'b0, NO_READING},
         '{REQ_UNUSED, 12'hfff, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'hfff, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'hfff, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'hfff, 1'b0, NO_READING},
         // full-scale average leaves the first-update state charging
         '{REQ_TICK, 12'h000, 1'b1,
           '{12'd2530, 7'd100, 1'b1, 1'b0, 1'b0, 12'd4095, 1'b1}},
         '{REQ_REF, 12'h000, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h000, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h000, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h000, 1'b0, NO_READING},
         '{REQ_TICK, 12'h000, 1'b0, NO_READING},
         // fill the FIFO, last sample is dropped
         '{REQ_SAMPLE, 12'h800, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h001, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h7ff, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'haaa, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h555, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'hfff, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h400, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h3c0, 1'b0, NO_READING},
         '{REQ_SAMPLE, 12'h123, 1'b0, NO_READING},
         '{REQ_TICK, 12'h000, 1'b0, NO_READING},
         '{REQ_TICK, 12'h000, 1'b0, NO_READING},
         '{REQ_TICK, 12'h000, 1'b0, NO_READING}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      verify_settings();

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(directed_rows[i].kind, directed_rows[i].sample);
         if (directed_rows[i].typed)
            pending_readings[pending_readings.size() - 1] = directed_rows[i].want;
      end
      ad_level = 1000;
      random_stretch(200);
      wait_drained();

      next_setting[REG_SCALE_GAIN] = $urandom_range(700000, 600000);
      next_setting[REG_DROP] = $urandom_range(40);
      next_setting[REG_CUTOFF] = $urandom_range(600, 500);
      next_setting[REG_FULL_CHARGE] = $urandom_range(800, 650);
      next_setting[REG_FULL_DISCH] = $urandom_range(720, 620);
      next_setting[REG_SLOPE] = $urandom_range(20);
      next_setting[REG_LOW_SET] = $urandom_range(50);
      next_setting[REG_LOW_CLEAR] = $urandom_range(100, 20);
      load_settings();
      send_idle_pct = 48;
      random_stretch(200);
      wait_drained();

      next_setting = '{32'd4194303, 32'd255, 32'd0, 32'd4095, 32'd4095, 32'd255,
                       32'd100, 32'd100};
      load_settings();
      send_idle_pct = 0;
      recv_stall_pct = 48;
      ad_level = 300;
      random_stretch(150);
      wait_drained();

      // zero gain, both full voltages at or under cut-off
      next_setting = '{32'd0, 32'd255, 32'd4095, 32'd0, 32'd4095, 32'd0, 32'd0, 32'd0};
      load_settings();
      send_idle_pct = 19;
      recv_stall_pct = 19;
      random_stretch(50);
      wait_drained();

      // range only degenerate while discharging
      next_setting = '{32'd1048576, 32'd0, 32'd1000, 32'd3000, 32'd1000, 32'd0, 32'd0,
                       32'd100};
      load_settings();
      ad_level = 1500;
      random_stretch(100);
      wait_drained();

      next_setting = '{32'(SCALE_GAIN_RST), 32'd3, 32'd560, 32'd705, 32'd655, 32'd2,
                       32'd20, 32'd40};
      load_settings();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      ad_level = 1000;
      // hold results back so the output fills and the input stalls
      hold_request = 1'b1;
      random_stretch(60);
      send_idle_pct = 19;
      recv_stall_pct = 19;
      random_stretch(200);
      wait_drained();

      $display("Ran %0d requests through six register settings: FIFO overflow, trend hold-off,",
               requests_sent);
      $display("degenerate ranges and a %0d-cycle result hold-off; %0d readings compared.",
               HOLD_OFF_CYCLES, readings_checked);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 8);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bvm_pkg.sv
rtl/bvm_ctrl.sv
rtl/bvm_datapath.sv
rtl/battery_voltage_monitor_core.sv
tb/sv/testbench.sv
